// ===== rtl/lzss_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
// No dependencies; lzss_ctrl, the top level and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package lzss_pkg;

  // window geometry
  localparam int unsigned WIN_AW = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned MLEN_W = 5;

  // write pointer start and shortest match
  localparam logic [WIN_AW-1:0] WP_START  = 12'd4078;
  localparam logic [MLEN_W-1:0] MIN_MATCH = 5'd3;

  // one result word offered by the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              run_last;
    logic              stream_done;
  } emit_t;

endpackage

// ===== rtl/lzss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lzss_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lzss_ctrl.sv =====
// Token sequencer: flag/literal/reference parsing, window clear and copy loop.
// Depends on lzss_pkg; drives the window RAM ports and offers result words.
`timescale 1ns / 1ps

module lzss_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lzss_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                cfg_valid,
  input  logic [lzss_pkg::LEN_W-1:0]          cfg_data,
  input  logic                                slot_free,
  output lzss_pkg::emit_t                     emit,
  output logic                                ram_we,
  output logic [lzss_pkg::WIN_AW-1:0]         ram_waddr,
  output logic [lzss_pkg::BYTE_W-1:0]         ram_wdata,
  output logic                                ram_re,
  output logic [lzss_pkg::WIN_AW-1:0]         ram_raddr,
  input  logic [lzss_pkg::BYTE_W-1:0]         ram_rdata
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LIT   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_REF2  = 2'd2;

  localparam logic [lzss_pkg::WIN_AW-1:0] ADDR_LAST = '1;
  localparam logic [lzss_pkg::WIN_AW-1:0] ADDR_ONE  = {{(lzss_pkg::WIN_AW-1){1'b0}}, 1'b1};

  logic [2:0]                        state;
  logic [lzss_pkg::WIN_AW-1:0]       clear_addr;
  logic [lzss_pkg::WIN_AW-1:0]       wp;
  logic [lzss_pkg::WIN_AW-1:0]       pos;
  logic [lzss_pkg::MLEN_W-1:0]       len_left;
  logic [lzss_pkg::BYTE_W-1:0]       flag_bits;
  logic [2:0]                        flag_index;
  logic [1:0]                        phase;
  logic [lzss_pkg::BYTE_W-1:0]       ref_low;
  logic [lzss_pkg::BYTE_W-1:0]       lit_byte;
  logic [lzss_pkg::LEN_W-1:0]        bytes_emitted;
  logic [lzss_pkg::LEN_W-1:0]        out_len;

  logic                              in_fire;
  logic                              finished;
  logic [lzss_pkg::LEN_W-1:0]        emitted_inc;
  logic [2:0]                        flag_index_inc;
  logic                              token_done;

  assign in_ready       = (state == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign finished       = (bytes_emitted >= out_len);
  assign emitted_inc    = bytes_emitted + {{(lzss_pkg::LEN_W-1){1'b0}}, 1'b1};
  assign flag_index_inc = flag_index + 3'd1;

  // offer a result word and drive the window ports
  always_comb begin
    emit             = '0;
    emit.stream_done = (emitted_inc == out_len);
    if (state == ST_LIT) begin
      emit.valid    = slot_free;
      emit.data     = lit_byte;
      emit.run_last = 1'b1;
    end else if (state == ST_WR) begin
      emit.valid    = slot_free;
      emit.data     = ram_rdata;
      emit.run_last = (len_left == 5'd1) || emit.stream_done;
    end
    if (!emit.valid) begin
      emit.stream_done = 1'b0;
    end
    token_done = emit.valid && emit.run_last;

    ram_we    = (state == ST_CLEAR) || emit.valid;
    ram_waddr = (state == ST_CLEAR) ? clear_addr : wp;
    ram_wdata = (state == ST_CLEAR) ? '0 : emit.data;
    ram_re    = (state == ST_RD);
    ram_raddr = pos;
  end

  // hold the length register; writes land at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      out_len <= '0;
    end else if (cfg_valid) begin
      out_len <= cfg_data;
    end
  end

  // advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_addr    <= '0;
      wp            <= lzss_pkg::WP_START;
      pos           <= '0;
      len_left      <= '0;
      flag_bits     <= '0;
      flag_index    <= '0;
      phase         <= PH_FLAG;
      ref_low       <= '0;
      lit_byte      <= '0;
      bytes_emitted <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + ADDR_ONE;
          if (clear_addr == ADDR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // drop the word once the stream is finished
          if (in_fire && !finished) begin
            case (phase)
              PH_TOKEN: begin
                if (flag_bits[flag_index]) begin
                  lit_byte <= in_byte;
                  state    <= ST_LIT;
                end else begin
                  ref_low <= in_byte;
                  phase   <= PH_REF2;
                end
              end
              PH_REF2: begin
                pos      <= {in_byte[7:4], ref_low};
                len_left <= {1'b0, in_byte[3:0]} + lzss_pkg::MIN_MATCH;
                state    <= ST_RD;
              end
              default: begin
                flag_bits  <= in_byte;
                flag_index <= '0;
                phase      <= PH_TOKEN;
              end
            endcase
          end
        end
        ST_LIT, ST_WR: begin
          if (emit.valid) begin
            wp            <= wp + ADDR_ONE;
            pos           <= pos + ADDR_ONE;
            len_left      <= len_left - 5'd1;
            bytes_emitted <= emitted_inc;
            if (token_done) begin
              flag_index <= flag_index_inc;
              phase      <= (flag_index_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
              state      <= ST_IDLE;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a read is always followed by its write-back cycle
  a_rd_then_wr: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> state == ST_WR)
    else $error("copy read not followed by write-back");

  // no input taken while the window is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("input ready during window clear");

  // the window is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("window read and write overlap");

  // the final byte of the stream always closes its token
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit.stream_done |-> emit.run_last)
    else $error("stream end without run end");

  // a result word is offered only into a free output slot
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> slot_free)
    else $error("result word offered to a full output slot");

endmodule

// ===== rtl/lzss_stream_decompressor.sv =====
// LZSS stream decompressor top level: sequencer, 4096-byte window RAM, output register.
// Depends on lzss_pkg, lzss_ram and lzss_ctrl.
// Flow: a flag byte or first reference byte is taken in the idle state, a literal passes
// through its own state, and a reference copies each byte by one window read then one write-back.
// Input is not ready until a literal or copy is through; each result word is registered out.
// Reset: synchronous; the window is then cleared over every address, input not ready.
`timescale 1ns / 1ps

module lzss_stream_decompressor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lzss_pkg::BYTE_W-1:0]       compressed_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lzss_pkg::BYTE_W-1:0]       out_byte,
  output logic                              run_last,
  output logic                              stream_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lzss_pkg::LEN_W-1:0]        output_length
);

  lzss_pkg::emit_t                  emit;
  logic                             slot_free;
  logic                             ram_we;
  logic [lzss_pkg::WIN_AW-1:0]      ram_waddr;
  logic [lzss_pkg::BYTE_W-1:0]      ram_wdata;
  logic                             ram_re;
  logic [lzss_pkg::WIN_AW-1:0]      ram_raddr;
  logic [lzss_pkg::BYTE_W-1:0]      ram_rdata;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;

  lzss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (compressed_byte),
    .cfg_valid (cfg_valid),
    .cfg_data  (output_length),
    .slot_free (slot_free),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lzss_ram #(
    .DATA_W (lzss_pkg::BYTE_W),
    .ADDR_W (lzss_pkg::WIN_AW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // load payload with each new word
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_byte    <= emit.data;
      run_last    <= emit.run_last;
      stream_done <= emit.stream_done;
    end
  end

endmodule

// ===== sim/tb_lzss_stream_decompressor.sv =====
// Self-checking testbench for lzss_stream_decompressor: random flag/literal/reference streams,
// a bit-exact decoder alongside, random idling on both channels and a long output stall.
// Depends on lzss_pkg and the decompressor RTL only.
`timescale 1ns / 1ps

module tb_lzss_stream_decompressor;

  localparam int unsigned TIMEOUT_CYCLES   = 600000;
  localparam int unsigned SETTLE_CYCLES    = 64;
  localparam int unsigned ITEMS_PER_PHASE  = 58;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  typedef enum logic [1:0] {EXPECT_FLAG, EXPECT_TOKEN, EXPECT_REF_HI} parse_t;

  typedef logic [lzss_pkg::WIN_AW-1:0] ptr_t;

  typedef struct packed {
    logic [lzss_pkg::BYTE_W-1:0] data;
    logic                        run_last;
    logic                        stream_done;
  } dec_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [lzss_pkg::BYTE_W-1:0] compressed_byte = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [lzss_pkg::BYTE_W-1:0] out_byte;
  logic                        run_last;
  logic                        stream_done;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [lzss_pkg::LEN_W-1:0]  output_length = '0;

  // decoder state kept alongside the block
  logic [lzss_pkg::BYTE_W-1:0] hist [0:(1<<lzss_pkg::WIN_AW)-1];
  ptr_t                        wr_ptr;
  logic [lzss_pkg::BYTE_W-1:0] flag_byte;
  logic [2:0]                  flag_idx;
  parse_t                      dec_phase;
  logic [lzss_pkg::BYTE_W-1:0] ref_lo;
  int unsigned                 emitted;
  logic [lzss_pkg::LEN_W-1:0]  out_len;
  int unsigned                 useful_items;
  dec_word_t                   expected_bytes [$];
  dec_word_t                   held_word;
  bit                          have_held;

  // stimulus and flow control
  logic [lzss_pkg::BYTE_W-1:0] byte_queue [$];
  int unsigned       errors = 0;
  int unsigned       cycle_count = 0;
  bit                quiet = 1'b0;
  bit                long_hold_req = 1'b0;
  int unsigned       in_gap;
  int unsigned       rdy_gap;
  int unsigned       hold_left;
  bit                hold_fired;

  lzss_stream_decompressor uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .compressed_byte (compressed_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .run_last        (run_last),
    .stream_done     (stream_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .output_length   (output_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Write one decoded byte into the window and stage its expected word; the previous
  // staged word is released so the last one of a run can still get run_last.
  task automatic emit_byte(input logic [lzss_pkg::BYTE_W-1:0] v);
    hist[wr_ptr] = v;
    wr_ptr = wr_ptr + ptr_t'(1);
    emitted++;
    if (have_held) expected_bytes.push_back(held_word);
    held_word = '{data: v, run_last: 1'b0, stream_done: (emitted == out_len)};
    have_held = 1'b1;
  endtask

  task automatic next_token;
    flag_idx = flag_idx + 3'd1;
    dec_phase = (flag_idx == 3'd0) ? EXPECT_FLAG : EXPECT_TOKEN;
  endtask

  // Decode one accepted compressed word and queue the bytes it yields.
  task automatic decode_byte(input logic [lzss_pkg::BYTE_W-1:0] b);
    ptr_t              pos;
    int unsigned       left;
    // drop everything once the configured length is reached
    if (emitted >= out_len) return;
    useful_items++;
    have_held = 1'b0;
    case (dec_phase)
      EXPECT_TOKEN: begin
        if (flag_byte[flag_idx]) begin
          emit_byte(b);
          next_token();
        end else begin
          ref_lo = b;
          dec_phase = EXPECT_REF_HI;
        end
      end
      EXPECT_REF_HI: begin
        pos = {b[7:4], ref_lo};
        left = 32'(b[3:0]) + 32'(lzss_pkg::MIN_MATCH);
        // copy byte by byte so overlapping matches repeat fresh output; stop at the length
        while (left > 0 && emitted < out_len) begin
          emit_byte(hist[pos]);
          pos = pos + ptr_t'(1);
          left--;
        end
        next_token();
      end
      default: begin
        flag_byte = b;
        flag_idx = '0;
        dec_phase = EXPECT_TOKEN;
      end
    endcase
    if (have_held) begin
      held_word.run_last = 1'b1;
      expected_bytes.push_back(held_word);
    end
  endtask

  // Track config and input words, check every output word against the oldest expectation.
  always @(posedge clk) begin : monitor
    dec_word_t got;
    dec_word_t want;
    if (rst) begin
      for (int i = 0; i < (1 << lzss_pkg::WIN_AW); i++) hist[i] = '0;
      wr_ptr = lzss_pkg::WP_START;
      flag_byte = '0;
      flag_idx = '0;
      dec_phase = EXPECT_FLAG;
      ref_lo = '0;
      emitted = 0;
      out_len = '0;
      useful_items = 0;
      have_held = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) out_len = output_length;
      if (in_valid && in_ready) decode_byte(compressed_byte);
      if (out_valid && out_ready) begin
        got = '{data: out_byte, run_last: run_last, stream_done: stream_done};
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("output word %02h with nothing expected", got.data));
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data)
            flag_error($sformatf("out_byte %02h, expected %02h", got.data, want.data));
          if (got.run_last !== want.run_last)
            flag_error($sformatf("run_last %b, expected %b (byte %02h)",
                                 got.run_last, want.run_last, want.data));
          if (got.stream_done !== want.stream_done)
            flag_error($sformatf("stream_done %b, expected %b (byte %02h)",
                                 got.stream_done, want.stream_done, want.data));
        end
      end
    end
  end

  // Offer queued words; after a word goes out, sometimes idle for a burst.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (byte_queue.size() > 0) begin
        in_valid <= 1'b1;
        compressed_byte <= byte_queue.pop_front();
        if (!quiet && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random stall bursts, plus one long hold so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rdy_gap <= 0;
      hold_left <= 0;
      hold_fired <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_fired) begin
      out_ready <= 1'b0;
      hold_fired <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES - 1;
    end else if (rdy_gap > 0) begin
      out_ready <= 1'b0;
      rdy_gap <= rdy_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      rdy_gap <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Write output_length through its own channel, then return on a falling edge.
  task automatic write_length(input logic [lzss_pkg::LEN_W-1:0] len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    output_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for all words to go in and all expected bytes to come out, then let the block settle.
  task automatic wait_drained;
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Feed a well-formed stream with random content until enough words were decoded or
  // the length is reached; resync the encoder to the decoder whenever nothing is in flight.
  task automatic queue_stream(input int unsigned target);
    int unsigned       base;
    parse_t            gp;
    logic [7:0]        gf;
    logic [2:0]        gi;
    ptr_t              gwp;
    ptr_t              pos;
    logic [3:0]        lc;
    base = useful_items;
    gp = dec_phase;
    gf = flag_byte;
    gi = flag_idx;
    gwp = wr_ptr;
    while (useful_items - base < target && emitted < out_len) begin
      @(negedge clk);
      if (byte_queue.size() == 0 && !in_valid) begin
        gp = dec_phase;
        gf = flag_byte;
        gi = flag_idx;
        gwp = wr_ptr;
      end
      if (byte_queue.size() == 0) begin
        if ($urandom_range(0, 39) == 0) begin
          // stray word: breaks token alignment until the next resync
          byte_queue.push_back(8'($urandom_range(0, 255)));
        end else if (gp == EXPECT_FLAG) begin
          case ($urandom_range(0, 5))
            0:       gf = 8'h00;
            1:       gf = 8'hFF;
            default: gf = 8'($urandom_range(0, 255));
          endcase
          byte_queue.push_back(gf);
          gi = '0;
          gp = EXPECT_TOKEN;
        end else begin
          if (gp == EXPECT_TOKEN && gf[gi]) begin
            byte_queue.push_back(8'($urandom_range(0, 255)));
            gwp = gwp + ptr_t'(1);
          end else if (gp == EXPECT_TOKEN) begin
            // mostly near the write pointer, tight distances give overlapping copies
            case ($urandom_range(0, 3))
              0:       pos = ptr_t'($urandom_range(0, (1 << lzss_pkg::WIN_AW) - 1));
              1:       pos = gwp - ptr_t'($urandom_range(1, 3));
              2:       pos = gwp - ptr_t'($urandom_range(1, 60));
              default: pos = gwp - ptr_t'($urandom_range(1, 1000));
            endcase
            lc = 4'($urandom_range(0, 15));
            byte_queue.push_back(pos[7:0]);
            byte_queue.push_back({pos[11:8], lc});
            gwp = gwp + ptr_t'(lc) + ptr_t'(lzss_pkg::MIN_MATCH);
          end else begin
            byte_queue.push_back(8'($urandom_range(0, 255)));
          end
          gi = gi + 3'd1;
          gp = (gi == 3'd0) ? EXPECT_FLAG : EXPECT_TOKEN;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] demo [0:13];
    // flag A5: literal, overlapping reference, literal, reference from the cleared area,
    // reference that wraps the window end, literal, reference cut at 45 bytes,
    // then a literal and a stray word that must be dropped
    demo = '{8'hA5, 8'h00, 8'hEE, 8'hF0, 8'hFF, 8'h00, 8'h0F, 8'hF0, 8'hFF,
             8'h80, 8'h01, 8'h05, 8'h7F, 8'h55};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // length is zero out of reset: words are taken and dropped
    @(negedge clk);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    wait_drained();

    write_length(32'd45);
    foreach (demo[i]) byte_queue.push_back(demo[i]);
    wait_drained();

    // raise the length mid-stream and hold the output long enough to back up the input
    write_length('1);
    long_hold_req = 1'b1;
    queue_stream(ITEMS_PER_PHASE);
    wait_drained();

    // length below the count already produced: drop words
    write_length(32'd5);
    byte_queue.push_back(8'($urandom_range(0, 255)));
    byte_queue.push_back(8'($urandom_range(0, 255)));
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) begin
        write_length('1);
        quiet = 1'b1;
      end else if (p % 2 == 0) begin
        write_length(emitted + $urandom_range(20, 400));
      end else begin
        write_length(emitted + 32'd4000);
      end
      queue_stream(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
